// File: hw/rtl/ordered_key_list_engine_unit_macros.svh
// Assertion shorthands used by the engine RTL file.
`ifndef ORDERED_KEY_LIST_ENGINE_UNIT_MACROS_SVH
`define ORDERED_KEY_LIST_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication.
`define OKL_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OKL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/okl_pkg.sv
`timescale 1ns / 1ps
package okl_pkg;

  typedef logic [2:0] action_t;

  localparam action_t ACT_INSERT     = 3'd0;
  localparam action_t ACT_MOVE_POS   = 3'd1;
  localparam action_t ACT_MOVE_KEY   = 3'd2;
  localparam action_t ACT_REMOVE_POS = 3'd3;
  localparam action_t ACT_REMOVE_KEY = 3'd4;
  localparam action_t ACT_CLEAR      = 3'd5;
  localparam action_t ACT_READ       = 3'd6;
  localparam action_t ACT_FIND       = 3'd7;

endpackage

// File: hw/rtl/okl_req_if.sv
`timescale 1ns / 1ps
interface okl_req_if #(
  parameter int POS_W    = 7,
  parameter int TPOS_W   = 6,
  parameter int KEY_BITS = 31
);
  logic                valid;
  logic                ready;
  okl_pkg::action_t    action;
  logic [POS_W-1:0]    position;
  logic [TPOS_W-1:0]   target_position;
  logic [KEY_BITS-1:0] key;
  logic [KEY_BITS-1:0] target_key;

  modport source (output valid, action, position, target_position, key, target_key,
                  input ready);
  modport sink   (input valid, action, position, target_position, key, target_key,
                  output ready);
endinterface

// File: hw/rtl/okl_rsp_if.sv
`timescale 1ns / 1ps
interface okl_rsp_if #(
  parameter int FPOS_W   = 6,
  parameter int KEY_BITS = 31
);
  logic                valid;
  logic                ready;
  logic                ok;
  logic [FPOS_W-1:0]   found_position;
  logic [KEY_BITS-1:0] read_key;

  modport source (output valid, ok, found_position, read_key, input ready);
  modport sink   (input valid, ok, found_position, read_key, output ready);
endinterface

// File: hw/rtl/okl_cell.sv
`timescale 1ns / 1ps
// One slot of the key ring: takes its right neighbor's key on every shift.
module okl_cell #(
  parameter int KEY_BITS = 31
) (
  input  logic                clk,
  input  logic                shift,
  input  logic [KEY_BITS-1:0] din,
  output logic [KEY_BITS-1:0] dout
);

  logic [KEY_BITS-1:0] key;

  always_ff @(posedge clk) begin
    if (shift) begin
      key <= din;
    end
  end

  assign dout = key;

endmodule

// File: hw/rtl/ordered_key_list_engine_unit.sv
`timescale 1ns / 1ps
// Channel  Role    Payload
// req      sink    action, position, target_position, key, target_key
// rsp      source  ok, found_position, read_key
//
// Keys sit in a ring of DEPTH cells that rotates one slot per cycle, during the
// scan and rewrite passes only, past a controller at cell 0. Every item takes
// one full rotation to search and read; a successful insert, move or remove
// takes a second rotation that rewrites the stream. Synchronous reset empties
// the list. A new item is taken while a result still waits on rsp; a stalled
// rsp holds the finished item until its result register frees.
`include "ordered_key_list_engine_unit_macros.svh"
module ordered_key_list_engine_unit #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 31
) (
  input logic        clk,
  input logic        rst,
  okl_req_if.sink    req,
  okl_rsp_if.source  rsp
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_EDIT   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]          state;
  logic [IDX_W-1:0]    j;
  logic [CNT_W-1:0]    count;

  okl_pkg::action_t    act;
  logic [CNT_W-1:0]    pos;
  logic [IDX_W-1:0]    tpos;
  logic [KEY_BITS-1:0] k;
  logic [KEY_BITS-1:0] tk;

  logic                hit_a;
  logic                hit_b;
  logic [IDX_W-1:0]    pos_a;
  logic [IDX_W-1:0]    pos_b;
  logic [KEY_BITS-1:0] rd;

  logic [IDX_W-1:0]    src;
  logic [IDX_W-1:0]    dst;
  logic [KEY_BITS-1:0] moved;
  logic [KEY_BITS-1:0] hold;

  logic                res_ok;
  logic [IDX_W-1:0]    res_fpos;
  logic [KEY_BITS-1:0] res_rkey;

  logic                out_valid;
  logic                out_ok;
  logic [IDX_W-1:0]    out_fpos;
  logic [KEY_BITS-1:0] out_rkey;

  logic                dec_ok;
  logic                dec_edit;
  logic [IDX_W-1:0]    dec_src;
  logic [IDX_W-1:0]    dec_dst;
  logic [KEY_BITS-1:0] dec_moved;
  logic [CNT_W-1:0]    dec_count;
  logic [IDX_W-1:0]    dec_fpos;
  logic [KEY_BITS-1:0] dec_rkey;

  logic                shift;
  logic                j_last;
  logic                in_list;
  logic [KEY_BITS-1:0] head0;
  logic [KEY_BITS-1:0] head1;
  logic [KEY_BITS-1:0] tail;
  logic [KEY_BITS-1:0] link [0:DEPTH];

  // Ring of cells: cell i takes cell i+1, the last cell takes the tail.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    okl_cell #(.KEY_BITS(KEY_BITS)) u_cell (
      .clk   (clk),
      .shift (shift),
      .din   (link[i+1]),
      .dout  (link[i])
    );
  end

  assign link[DEPTH] = tail;
  assign head0       = link[0];
  assign head1       = link[1];

  assign shift   = (state == ST_SCAN) || (state == ST_EDIT);
  assign j_last  = (j == IDX_W'(DEPTH - 1));
  assign in_list = (CNT_W'(j) < count);

  // Rewrite of the stream: position j leaves cell 0 and its new value enters
  // the tail, so after a full rotation the tail value sits at position j.
  always_comb begin
    tail = head0;
    if (state == ST_EDIT) begin
      case (act)
        okl_pkg::ACT_INSERT: begin
          if (j == src) begin
            tail = k;
          end else if (j > src) begin
            tail = hold;
          end
        end
        okl_pkg::ACT_MOVE_POS, okl_pkg::ACT_MOVE_KEY: begin
          if (j == dst) begin
            tail = moved;
          end else if ((src < dst) && (j >= src) && (j < dst)) begin
            tail = head1;
          end else if ((src > dst) && (j > dst) && (j <= src)) begin
            tail = hold;
          end
        end
        okl_pkg::ACT_REMOVE_POS, okl_pkg::ACT_REMOVE_KEY: begin
          if (j >= src) begin
            tail = head1;
          end
        end
        default: tail = head0;
      endcase
    end
  end

  always_comb begin
    dec_ok    = 1'b0;
    dec_edit  = 1'b0;
    dec_src   = pos[IDX_W-1:0];
    dec_dst   = tpos;
    dec_moved = rd;
    dec_count = count;
    dec_fpos  = '0;
    dec_rkey  = '0;
    case (act)
      okl_pkg::ACT_INSERT: begin
        dec_ok   = (pos <= count) && !hit_a && (count < CNT_W'(DEPTH));
        dec_edit = 1'b1;
        if (dec_ok) begin
          dec_count = count + CNT_W'(1);
        end
      end
      okl_pkg::ACT_MOVE_POS: begin
        dec_ok   = (pos < count) && (CNT_W'(tpos) < count);
        dec_edit = 1'b1;
      end
      okl_pkg::ACT_MOVE_KEY: begin
        dec_ok    = hit_a && hit_b;
        dec_edit  = 1'b1;
        dec_src   = pos_a;
        dec_dst   = pos_b;
        dec_moved = k;
      end
      okl_pkg::ACT_REMOVE_POS: begin
        dec_ok   = (pos < count);
        dec_edit = 1'b1;
        if (dec_ok) begin
          dec_count = count - CNT_W'(1);
        end
      end
      okl_pkg::ACT_REMOVE_KEY: begin
        dec_ok   = hit_a;
        dec_edit = 1'b1;
        dec_src  = pos_a;
        if (dec_ok) begin
          dec_count = count - CNT_W'(1);
        end
      end
      okl_pkg::ACT_CLEAR: begin
        dec_ok    = 1'b1;
        dec_count = '0;
      end
      okl_pkg::ACT_READ: begin
        dec_ok = (pos < count);
        if (dec_ok) begin
          dec_rkey = rd;
        end
      end
      okl_pkg::ACT_FIND: begin
        dec_ok = hit_a;
        if (hit_a) begin
          dec_fpos = pos_a;
        end
      end
      default: dec_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // FINISH reloads the result register itself
      if (out_valid && rsp.ready && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            act   <= req.action;
            pos   <= req.position;
            tpos  <= req.target_position;
            k     <= req.key;
            tk    <= req.target_key;
            hit_a <= 1'b0;
            hit_b <= 1'b0;
            j     <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // keep the first match only
          if (in_list && (head0 == k) && !hit_a) begin
            hit_a <= 1'b1;
            pos_a <= j;
          end
          if (in_list && (head0 == tk) && !hit_b) begin
            hit_b <= 1'b1;
            pos_b <= j;
          end
          if (CNT_W'(j) == pos) begin
            rd <= head0;
          end
          j <= j_last ? '0 : j + IDX_W'(1);
          if (j_last) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          res_ok   <= dec_ok;
          res_fpos <= dec_fpos;
          res_rkey <= dec_rkey;
          src      <= dec_src;
          dst      <= dec_dst;
          moved    <= dec_moved;
          count    <= dec_count;
          state    <= (dec_ok && dec_edit) ? ST_EDIT : ST_FINISH;
        end
        ST_EDIT: begin
          hold <= head0;
          j    <= j_last ? '0 : j + IDX_W'(1);
          if (j_last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_ok    <= res_ok;
            out_fpos  <= res_fpos;
            out_rkey  <= res_rkey;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign req.ready          = (state == ST_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.ok             = out_ok;
  assign rsp.found_position = out_fpos;
  assign rsp.read_key       = out_rkey;

  `OKL_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH), "entry count past depth")
  `OKL_ASSERT_NEXT(a_accept_scan, clk, rst, req.valid && req.ready, state == ST_SCAN, "transfer did not start a scan")
  `OKL_ASSERT_IMPL(a_ring_aligned, clk, rst, state == ST_DECIDE, j == '0, "ring out of step after scan")
  `OKL_ASSERT_IMPL(a_edit_ok, clk, rst, state == ST_EDIT, res_ok, "rewrite pass on a failed action")
  `OKL_ASSERT_IMPL(a_fail_zero, clk, rst, out_valid && !out_ok, (out_fpos == '0) && (out_rkey == '0), "failed result carries data")

endmodule
